// File: hw/rtl/i2cmra_pkg.sv
// types, constants and phase codes for the i2c master register access unit
package i2cmra_pkg;

  localparam logic [2:0] MODE_TICK       = 3'd0;
  localparam logic [2:0] MODE_BEGIN_WR   = 3'd1;
  localparam logic [2:0] MODE_BEGIN_RD   = 3'd2;
  localparam logic [2:0] MODE_NEXT_BYTE  = 3'd3;
  localparam logic [2:0] MODE_CLEAR_NACK = 3'd4;

  localparam logic [7:0] ADDR_WRITE_MASK = 8'hFE;
  localparam logic [7:0] ADDR_READ_BIT   = 8'h01;
  localparam logic [7:0] MSB_BIT         = 8'h80;

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_START   = 4'd1;
  localparam logic [3:0] PH_ADDR_W  = 4'd2;
  localparam logic [3:0] PH_ACK_AW  = 4'd3;
  localparam logic [3:0] PH_REG     = 4'd4;
  localparam logic [3:0] PH_ACK_REG = 4'd5;
  localparam logic [3:0] PH_RSTART  = 4'd6;
  localparam logic [3:0] PH_ADDR_R  = 4'd7;
  localparam logic [3:0] PH_ACK_AR  = 4'd8;
  localparam logic [3:0] PH_RECV    = 4'd9;
  localparam logic [3:0] PH_SACK    = 4'd10;
  localparam logic [3:0] PH_WAIT    = 4'd11;
  localparam logic [3:0] PH_DATA    = 4'd12;
  localparam logic [3:0] PH_ACK_D   = 4'd13;
  localparam logic [3:0] PH_STOP    = 4'd14;

  localparam logic [2:0] SEQ_NONE  = 3'd0;
  localparam logic [2:0] SEQ_START = 3'd1;
  localparam logic [2:0] SEQ_STOP  = 3'd2;
  localparam logic [2:0] SEQ_SEND  = 3'd3;
  localparam logic [2:0] SEQ_RECV  = 3'd4;
  localparam logic [2:0] SEQ_ACK   = 3'd5;
  localparam logic [2:0] SEQ_SACK  = 3'd6;

  typedef struct packed {
    logic [2:0] mode;
    logic       sda_in;
    logic [7:0] device_address;
    logic [7:0] register_address;
    logic [7:0] byte_count;
    logic [7:0] write_byte;
  } cmd_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
    logic       want_byte;
    logic       busy_res;
    logic       done_res;
    logic       nack_error;
  } res_t;

endpackage

// File: hw/rtl/i2c_master_register_access_unit.sv
// i2c master register access unit: tick-driven open-drain register read and write
//
// channel | direction | payload
// cmd     | in        | i2cmra_pkg::cmd_t, one tick or one command per transaction
// res     | out       | i2cmra_pkg::res_t, one result per command transaction
//
// one transaction per cycle while cmd_ready is high; each result is registered
// sequencer state and pin levels update in the cycle a transaction is accepted
// a two-entry output stage (result register plus skid register) holds results
// while res_ready is low; cmd_ready drops once both entries are full and during reset
// rst is synchronous and returns the pins to released with the bus idle
module i2c_master_register_access_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  i2cmra_pkg::cmd_t cmd,
  output logic             res_valid,
  input  logic             res_ready,
  output i2cmra_pkg::res_t res
);
  import i2cmra_pkg::*;

  logic [3:0] phase, phase_next;
  logic [1:0] micro, micro_next;
  logic [2:0] bit_index, bit_index_next;
  logic [7:0] shift_data, shift_data_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] address_hold, address_hold_next;
  logic [7:0] register_hold, register_hold_next;
  logic       reading, reading_next;
  logic       nack_flag, nack_flag_next;
  logic       scl_level, scl_level_next;
  logic       sda_level, sda_level_next;
  logic [7:0] pending_byte, pending_byte_next;
  logic       pending_valid, pending_valid_next;

  logic [2:0] seq;
  logic       fin;
  logic       rvalid, rlast, done;
  logic [7:0] rbyte;
  logic [7:0] bytes_dec;
  res_t       result;
  res_t       skid;
  logic       skid_valid;
  logic       push, pop;

  assign bytes_dec = bytes_left - 8'd1;

  always_comb begin
    case (phase)
      PH_START, PH_RSTART: seq = SEQ_START;
      PH_STOP: seq = SEQ_STOP;
      PH_ADDR_W, PH_REG, PH_ADDR_R, PH_DATA: seq = SEQ_SEND;
      PH_RECV: seq = SEQ_RECV;
      PH_ACK_AW, PH_ACK_REG, PH_ACK_AR, PH_ACK_D: seq = SEQ_ACK;
      PH_SACK: seq = SEQ_SACK;
      default: seq = SEQ_NONE;
    endcase
  end

  always_comb begin
    phase_next         = phase;
    micro_next         = micro;
    bit_index_next     = bit_index;
    shift_data_next    = shift_data;
    bytes_left_next    = bytes_left;
    address_hold_next  = address_hold;
    register_hold_next = register_hold;
    reading_next       = reading;
    nack_flag_next     = nack_flag;
    scl_level_next     = scl_level;
    sda_level_next     = sda_level;
    pending_byte_next  = pending_byte;
    pending_valid_next = pending_valid;
    fin    = 1'b0;
    rvalid = 1'b0;
    rlast  = 1'b0;
    rbyte  = 8'd0;
    done   = 1'b0;

    case (cmd.mode)
      MODE_BEGIN_WR, MODE_BEGIN_RD: begin
        if (phase == PH_IDLE) begin
          address_hold_next  = cmd.device_address;
          register_hold_next = cmd.register_address;
          reading_next       = (cmd.mode == MODE_BEGIN_RD);
          if (cmd.mode == MODE_BEGIN_RD && cmd.byte_count == 8'd0) begin
            bytes_left_next = 8'd1;
          end else begin
            bytes_left_next = cmd.byte_count;
          end
          pending_byte_next  = cmd.write_byte;
          pending_valid_next = (cmd.mode == MODE_BEGIN_WR) && (cmd.byte_count != 8'd0);
          micro_next         = 2'd0;
          bit_index_next     = 3'd0;
          phase_next         = PH_START;
        end
      end
      MODE_NEXT_BYTE: begin
        if (phase != PH_IDLE && !reading) begin
          pending_byte_next  = cmd.write_byte;
          pending_valid_next = 1'b1;
        end
      end
      MODE_CLEAR_NACK: begin
        nack_flag_next = 1'b0;
      end
      MODE_TICK: begin
        // pin-level micro sequence of the current phase
        case (seq)
          SEQ_START, SEQ_STOP: begin
            case (micro)
              2'd0: begin
                sda_level_next = (seq == SEQ_START);
                micro_next = 2'd1;
              end
              2'd1: begin
                scl_level_next = 1'b1;
                micro_next = 2'd2;
              end
              default: begin
                sda_level_next = (seq == SEQ_STOP);
                micro_next = 2'd0;
                fin = 1'b1;
              end
            endcase
          end
          SEQ_SEND, SEQ_RECV: begin
            case (micro)
              2'd0: begin
                if (seq == SEQ_SEND) begin
                  scl_level_next = 1'b0;
                end else begin
                  sda_level_next  = 1'b1;
                  shift_data_next = 8'd0;
                end
                bit_index_next = 3'd0;
                micro_next = 2'd1;
              end
              2'd1: begin
                if (seq == SEQ_SEND) begin
                  sda_level_next = shift_data[3'd7 - bit_index];
                end else begin
                  scl_level_next = 1'b1;
                end
                micro_next = 2'd2;
              end
              2'd2: begin
                if (seq == SEQ_SEND) begin
                  scl_level_next = 1'b1;
                end else if (cmd.sda_in) begin
                  shift_data_next = shift_data | (MSB_BIT >> bit_index);
                end
                micro_next = 2'd3;
              end
              default: begin
                scl_level_next = 1'b0;
                if (bit_index == 3'd7) begin
                  micro_next = 2'd0;
                  fin = 1'b1;
                end else begin
                  bit_index_next = bit_index + 3'd1;
                  micro_next = 2'd1;
                end
              end
            endcase
          end
          SEQ_ACK: begin
            case (micro)
              2'd0: begin
                sda_level_next = 1'b1;
                micro_next = 2'd1;
              end
              2'd1: begin
                scl_level_next = 1'b1;
                micro_next = 2'd2;
              end
              2'd2: begin
                if (cmd.sda_in) begin
                  nack_flag_next = 1'b1;
                end
                micro_next = 2'd3;
              end
              default: begin
                scl_level_next = 1'b0;
                micro_next = 2'd0;
                fin = 1'b1;
              end
            endcase
          end
          SEQ_SACK: begin
            case (micro)
              2'd0: begin
                sda_level_next = (bytes_left == 8'd0);
                micro_next = 2'd1;
              end
              2'd1: begin
                scl_level_next = 1'b1;
                micro_next = 2'd2;
              end
              2'd2: begin
                scl_level_next = 1'b0;
                micro_next = 2'd3;
              end
              default: begin
                sda_level_next = 1'b1;
                micro_next = 2'd0;
                fin = 1'b1;
              end
            endcase
          end
          default: ;
        endcase

        // phase transitions
        case (phase)
          PH_IDLE: ;
          PH_START: begin
            if (fin) begin
              shift_data_next = address_hold & ADDR_WRITE_MASK;
              phase_next = PH_ADDR_W;
            end
          end
          PH_ADDR_W: if (fin) phase_next = PH_ACK_AW;
          PH_ACK_AW: begin
            if (fin) begin
              shift_data_next = register_hold;
              phase_next = PH_REG;
            end
          end
          PH_REG: if (fin) phase_next = PH_ACK_REG;
          PH_ACK_REG: begin
            if (fin) begin
              if (reading) begin
                phase_next = PH_RSTART;
              end else if (bytes_left == 8'd0) begin
                phase_next = PH_STOP;
              end else begin
                phase_next = PH_WAIT;
              end
            end
          end
          PH_RSTART: begin
            if (fin) begin
              shift_data_next = address_hold | ADDR_READ_BIT;
              phase_next = PH_ADDR_R;
            end
          end
          PH_ADDR_R: if (fin) phase_next = PH_ACK_AR;
          PH_ACK_AR: if (fin) phase_next = PH_RECV;
          PH_RECV: begin
            if (fin) begin
              bytes_left_next = bytes_dec;
              rvalid = 1'b1;
              rbyte  = shift_data;
              rlast  = (bytes_dec == 8'd0);
              phase_next = PH_SACK;
            end
          end
          PH_SACK: begin
            if (fin) begin
              phase_next = (bytes_left == 8'd0) ? PH_STOP : PH_RECV;
            end
          end
          PH_WAIT: begin
            if (pending_valid) begin
              shift_data_next    = pending_byte;
              pending_valid_next = 1'b0;
              bytes_left_next    = bytes_dec;
              phase_next         = PH_DATA;
              // first step of the byte send happens on this tick
              scl_level_next     = 1'b0;
              bit_index_next     = 3'd0;
              micro_next         = 2'd1;
            end
          end
          PH_DATA: if (fin) phase_next = PH_ACK_D;
          PH_ACK_D: begin
            if (fin) begin
              phase_next = (bytes_left == 8'd0) ? PH_STOP : PH_WAIT;
            end
          end
          PH_STOP: begin
            if (fin) begin
              done = 1'b1;
              phase_next = PH_IDLE;
              reading_next = 1'b0;
              pending_valid_next = 1'b0;
            end
          end
          default: begin
            phase_next = PH_IDLE;
            micro_next = 2'd0;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    result.scl_out    = scl_level_next;
    result.sda_out    = sda_level_next;
    result.read_byte  = rbyte;
    result.read_valid = rvalid;
    result.read_last  = rlast;
    result.want_byte  = (phase_next == PH_WAIT) && !pending_valid_next;
    result.busy_res   = (phase_next != PH_IDLE);
    result.done_res   = done;
    result.nack_error = nack_flag_next;
  end

  assign cmd_ready = !rst && !skid_valid;
  assign push = cmd_valid && cmd_ready;
  assign pop  = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      micro         <= 2'd0;
      bit_index     <= 3'd0;
      shift_data    <= 8'd0;
      bytes_left    <= 8'd0;
      address_hold  <= 8'd0;
      register_hold <= 8'd0;
      reading       <= 1'b0;
      nack_flag     <= 1'b0;
      scl_level     <= 1'b1;
      sda_level     <= 1'b1;
      pending_byte  <= 8'd0;
      pending_valid <= 1'b0;
    end else if (push) begin
      phase         <= phase_next;
      micro         <= micro_next;
      bit_index     <= bit_index_next;
      shift_data    <= shift_data_next;
      bytes_left    <= bytes_left_next;
      address_hold  <= address_hold_next;
      register_hold <= register_hold_next;
      reading       <= reading_next;
      nack_flag     <= nack_flag_next;
      scl_level     <= scl_level_next;
      sda_level     <= sda_level_next;
      pending_byte  <= pending_byte_next;
      pending_valid <= pending_valid_next;
    end
  end

  // result register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (res_valid && !res_ready) begin
        skid_valid <= 1'b1;
      end else begin
        res_valid <= 1'b1;
      end
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        res <= skid;
      end
    end else if (push) begin
      if (res_valid && !res_ready) begin
        skid <= result;
      end else begin
        res <= result;
      end
    end
  end

  a_skid_behind_res: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid entry held without a result in front");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.done_res |-> !res.busy_res)
    else $error("stop completed while still busy");

  a_read_while_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.read_valid |-> res.busy_res && !res.want_byte)
    else $error("received byte outside a read");

  a_stall_scl_low: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.want_byte |-> !res.scl_out && res.busy_res)
    else $error("write stall with scl released");

endmodule

// File: tb/testbench.sv
// self-checking testbench for the i2c master register access unit
`timescale 1ns / 1ps

import i2cmra_pkg::*;

class register_access_scoreboard;
  logic [3:0] phase;
  logic [2:0] bit_idx;
  logic [1:0] step;
  logic [7:0] shifter;
  logic [7:0] remaining;
  logic [7:0] addr_q;
  logic [7:0] reg_q;
  logic [7:0] pend_byte;
  logic       is_read;
  logic       nack;
  logic       scl;
  logic       sda;
  logic       pend_ok;
  res_t       results_due[$];
  int         mismatches;
  int         checked;
  int         writes;
  int         reads;
  int         read_bytes;
  int         stops;

  function new();
    phase = PH_IDLE;
    bit_idx = '0;
    step = '0;
    shifter = '0;
    remaining = '0;
    addr_q = '0;
    reg_q = '0;
    pend_byte = '0;
    is_read = 1'b0;
    nack = 1'b0;
    scl = 1'b1;
    sda = 1'b1;
    pend_ok = 1'b0;
    mismatches = 0;
    checked = 0;
    writes = 0;
    reads = 0;
    read_bytes = 0;
    stops = 0;
  endfunction

  function bit start_seq();
    case (step)
      2'd0: begin sda = 1'b1; step = 2'd1; return 1'b0; end
      2'd1: begin scl = 1'b1; step = 2'd2; return 1'b0; end
      default: begin sda = 1'b0; step = 2'd0; return 1'b1; end
    endcase
  endfunction

  function bit stop_seq();
    case (step)
      2'd0: begin sda = 1'b0; step = 2'd1; return 1'b0; end
      2'd1: begin scl = 1'b1; step = 2'd2; return 1'b0; end
      default: begin sda = 1'b1; step = 2'd0; return 1'b1; end
    endcase
  endfunction

  function bit send_seq();
    case (step)
      2'd0: begin scl = 1'b0; bit_idx = '0; step = 2'd1; return 1'b0; end
      2'd1: begin sda = shifter[3'd7 - bit_idx]; step = 2'd2; return 1'b0; end
      2'd2: begin scl = 1'b1; step = 2'd3; return 1'b0; end
      default: begin
        scl = 1'b0;
        if (bit_idx == 3'd7) begin
          step = 2'd0;
          return 1'b1;
        end
        bit_idx = bit_idx + 3'd1;
        step = 2'd1;
        return 1'b0;
      end
    endcase
  endfunction

  function bit recv_seq(logic sda_in);
    case (step)
      2'd0: begin sda = 1'b1; bit_idx = '0; shifter = '0; step = 2'd1; return 1'b0; end
      2'd1: begin scl = 1'b1; step = 2'd2; return 1'b0; end
      2'd2: begin
        if (sda_in) shifter[3'd7 - bit_idx] = 1'b1;
        step = 2'd3;
        return 1'b0;
      end
      default: begin
        scl = 1'b0;
        if (bit_idx == 3'd7) begin
          step = 2'd0;
          return 1'b1;
        end
        bit_idx = bit_idx + 3'd1;
        step = 2'd1;
        return 1'b0;
      end
    endcase
  endfunction

  function bit ack_seq(logic sda_in);
    case (step)
      2'd0: begin sda = 1'b1; step = 2'd1; return 1'b0; end
      2'd1: begin scl = 1'b1; step = 2'd2; return 1'b0; end
      2'd2: begin
        if (sda_in) nack = 1'b1;
        step = 2'd3;
        return 1'b0;
      end
      default: begin scl = 1'b0; step = 2'd0; return 1'b1; end
    endcase
  endfunction

  function bit sendack_seq(logic level);
    case (step)
      2'd0: begin sda = level; step = 2'd1; return 1'b0; end
      2'd1: begin scl = 1'b1; step = 2'd2; return 1'b0; end
      2'd2: begin scl = 1'b0; step = 2'd3; return 1'b0; end
      default: begin sda = 1'b1; step = 2'd0; return 1'b1; end
    endcase
  endfunction

  function res_t bus_step(cmd_t c);
    res_t r;
    r = '0;
    if ((c.mode == MODE_BEGIN_WR || c.mode == MODE_BEGIN_RD) && phase == PH_IDLE) begin
      addr_q = c.device_address;
      reg_q = c.register_address;
      is_read = (c.mode == MODE_BEGIN_RD);
      remaining = c.byte_count;
      if (is_read && remaining == 8'd0) remaining = 8'd1;
      pend_byte = c.write_byte;
      pend_ok = !is_read && c.byte_count != 8'd0;
      step = '0;
      bit_idx = '0;
      phase = PH_START;
      if (is_read) reads++;
      else writes++;
    end else if (c.mode == MODE_NEXT_BYTE) begin
      if (phase != PH_IDLE && !is_read) begin
        pend_byte = c.write_byte;
        pend_ok = 1'b1;
      end
    end else if (c.mode == MODE_CLEAR_NACK) begin
      nack = 1'b0;
    end else if (c.mode == MODE_TICK) begin
      case (phase)
        PH_START: begin
          if (start_seq()) begin
            shifter = addr_q & ADDR_WRITE_MASK;
            phase = PH_ADDR_W;
          end
        end
        PH_ADDR_W: if (send_seq()) phase = PH_ACK_AW;
        PH_ACK_AW: begin
          if (ack_seq(c.sda_in)) begin
            shifter = reg_q;
            phase = PH_REG;
          end
        end
        PH_REG: if (send_seq()) phase = PH_ACK_REG;
        PH_ACK_REG: begin
          if (ack_seq(c.sda_in))
            phase = is_read ? PH_RSTART : (remaining == 8'd0 ? PH_STOP : PH_WAIT);
        end
        PH_RSTART: begin
          if (start_seq()) begin
            shifter = addr_q | ADDR_READ_BIT;
            phase = PH_ADDR_R;
          end
        end
        PH_ADDR_R: if (send_seq()) phase = PH_ACK_AR;
        PH_ACK_AR: if (ack_seq(c.sda_in)) phase = PH_RECV;
        PH_RECV: begin
          if (recv_seq(c.sda_in)) begin
            remaining = remaining - 8'd1;
            r.read_valid = 1'b1;
            r.read_byte = shifter;
            r.read_last = (remaining == 8'd0);
            phase = PH_SACK;
            read_bytes++;
          end
        end
        PH_SACK: begin
          if (sendack_seq(remaining == 8'd0))
            phase = (remaining == 8'd0) ? PH_STOP : PH_RECV;
        end
        PH_WAIT: begin
          if (pend_ok) begin
            shifter = pend_byte;
            pend_ok = 1'b0;
            remaining = remaining - 8'd1;
            step = '0;
            phase = PH_DATA;
            void'(send_seq());
          end
        end
        PH_DATA: if (send_seq()) phase = PH_ACK_D;
        PH_ACK_D: begin
          if (ack_seq(c.sda_in)) phase = (remaining == 8'd0) ? PH_STOP : PH_WAIT;
        end
        PH_STOP: begin
          if (stop_seq()) begin
            r.done_res = 1'b1;
            phase = PH_IDLE;
            is_read = 1'b0;
            pend_ok = 1'b0;
            stops++;
          end
        end
        PH_IDLE: ;
        default: begin
          phase = PH_IDLE;
          step = '0;
        end
      endcase
    end
    r.scl_out = scl;
    r.sda_out = sda;
    r.want_byte = (phase == PH_WAIT) && !pend_ok;
    r.busy_res = (phase != PH_IDLE);
    r.nack_error = nack;
    return r;
  endfunction

  function void note_command(cmd_t c);
    results_due.push_back(bus_step(c));
  endfunction

  task report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  task compare_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("result %0d: %s is %0d, expected %0d", checked, name, got, want));
  endtask

  task check_result(res_t got);
    res_t want;
    if (results_due.size() == 0) begin
      report_mismatch("result with no command waiting");
      return;
    end
    want = results_due.pop_front();
    if ($isunknown(got))
      report_mismatch($sformatf("result %0d: unknown bits %b", checked, got));
    compare_field("scl_out", got.scl_out, want.scl_out);
    compare_field("sda_out", got.sda_out, want.sda_out);
    compare_field("read_byte", got.read_byte, want.read_byte);
    compare_field("read_valid", got.read_valid, want.read_valid);
    compare_field("read_last", got.read_last, want.read_last);
    compare_field("want_byte", got.want_byte, want.want_byte);
    compare_field("busy_res", got.busy_res, want.busy_res);
    compare_field("done_res", got.done_res, want.done_res);
    compare_field("nack_error", got.nack_error, want.nack_error);
    checked++;
  endtask
endclass

module testbench;
  localparam logic [2:0] MODE_SPARE_A = 3'd5;
  localparam logic [2:0] MODE_SPARE_B = 3'd6;
  localparam logic [2:0] MODE_SPARE_C = 3'd7;
  localparam int RANDOM_CMDS = 850;
  localparam int SQUEEZE_AT = 300;
  localparam int TIMEOUT_CYCLES = 500000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;

  register_access_scoreboard sb;
  int  cycles = 0;
  int  live_cmds = 0;
  int  total_cmds = 0;
  int  burst_left = 0;
  bit  squeeze_pending = 1'b0;
  bit  sender_done = 1'b0;

  i2c_master_register_access_unit DUT (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == TIMEOUT_CYCLES) begin
      $display("** i2c_master_register_access_unit: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) sb.check_result(res);
  end

  function automatic int random_pause();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
  endfunction

  function automatic cmd_t make_cmd(logic [2:0] mode, logic sda_in, logic [7:0] saddr,
                                    logic [7:0] raddr, logic [7:0] count, logic [7:0] wbyte);
    cmd_t c;
    c.mode = mode;
    c.sda_in = sda_in;
    c.device_address = saddr;
    c.register_address = raddr;
    c.byte_count = count;
    c.write_byte = wbyte;
    return c;
  endfunction

  function automatic cmd_t pick_command();
    cmd_t c;
    int unsigned roll;
    c.mode = MODE_TICK;
    c.sda_in = (sb.phase == PH_RECV) ? 1'($urandom_range(0, 1))
                                     : ($urandom_range(0, 3) == 0);
    c.device_address = 8'($urandom_range(0, 255));
    c.register_address = 8'($urandom_range(0, 255));
    c.byte_count = 8'($urandom_range(0, 255));
    c.write_byte = 8'($urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    if (sb.phase == PH_IDLE) begin
      c.byte_count = ($urandom_range(0, 39) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, 3));
      if (roll < 88) c.mode = ($urandom_range(0, 1) != 0) ? MODE_BEGIN_RD : MODE_BEGIN_WR;
      else c.mode = 3'($urandom_range(0, 7));
    end else if (sb.phase == PH_WAIT && !sb.pend_ok && roll < 55) begin
      c.mode = MODE_NEXT_BYTE;
    end else if (roll > 94) begin
      c.mode = 3'($urandom_range(0, 7));
    end
    return c;
  endfunction

  task automatic drive_command(cmd_t c);
    int gap;
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      case ($urandom_range(0, 5))
        0: burst_left = $urandom_range(30, 120);
        1, 2: gap = random_pause();
        default: gap = 0;
      endcase
    end
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    if ((c.mode == MODE_TICK && sb.phase != PH_IDLE) ||
        ((c.mode == MODE_BEGIN_WR || c.mode == MODE_BEGIN_RD) && sb.phase == PH_IDLE) ||
        (c.mode == MODE_NEXT_BYTE && sb.phase != PH_IDLE && !sb.is_read) ||
        c.mode == MODE_CLEAR_NACK)
      live_cmds++;
    total_cmds++;
    sb.note_command(c);
  endtask

  initial begin : result_sink
    int hold_left;
    int calm_left;
    hold_left = 0;
    calm_left = 0;
    forever begin
      @(posedge clk);
      if (squeeze_pending) begin
        squeeze_pending = 1'b0;
        hold_left = 400;
        res_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        res_ready <= 1'b1;
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            calm_left = $urandom_range(20, 100);
            res_ready <= 1'b1;
          end
          1: begin
            hold_left = random_pause() - 1;
            res_ready <= 1'b0;
          end
          default: res_ready <= 1'b1;
        endcase
      end
    end
  end

  initial begin : command_source
    bit squeezed;
    squeezed = 1'b0;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // idle behaviour, spare modes and ignored commands
    drive_command(make_cmd(MODE_TICK, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    drive_command(make_cmd(MODE_SPARE_A, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    drive_command(make_cmd(MODE_SPARE_B, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
    drive_command(make_cmd(MODE_SPARE_C, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    drive_command(make_cmd(MODE_NEXT_BYTE, 1'b0, 8'h00, 8'h00, 8'h00, 8'hAA));
    drive_command(make_cmd(MODE_CLEAR_NACK, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
    // read with a zero byte count (run as a one-byte read), then commands that a busy read must ignore
    drive_command(make_cmd(MODE_BEGIN_RD, 1'b1, 8'hFF, 8'h00, 8'h00, 8'h55));
    drive_command(make_cmd(MODE_BEGIN_WR, 1'b1, 8'h00, 8'hFF, 8'hFF, 8'hFF));
    drive_command(make_cmd(MODE_BEGIN_RD, 1'b0, 8'h00, 8'hFF, 8'h00, 8'h00));
    drive_command(make_cmd(MODE_NEXT_BYTE, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'h00));
    for (int i = 0; i < 10; i++)
      drive_command(make_cmd(MODE_TICK, 1'(i), 8'h00, 8'h00, 8'h00, 8'h00));
    drive_command(make_cmd(MODE_CLEAR_NACK, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    drive_command(make_cmd(MODE_SPARE_C, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));

    live_cmds = 0;
    while (live_cmds < RANDOM_CMDS) begin
      if (!squeezed && live_cmds >= SQUEEZE_AT) begin
        squeezed = 1'b1;
        squeeze_pending = 1'b1;
      end
      drive_command(pick_command());
    end
    cmd_valid <= 1'b0;
    sender_done = 1'b1;
  end

  initial begin : run_control
    wait (sender_done);
    while (sb.results_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    $display("covered %0d commands (%0d acting), %0d results checked",
             total_cmds, live_cmds, sb.checked);
    $display("started %0d writes and %0d reads, %0d bytes read back, %0d stops seen",
             sb.writes, sb.reads, sb.read_bytes, sb.stops);
    if (sb.mismatches == 0) begin
      $display("** i2c_master_register_access_unit: PASSED **");
    end else begin
      $display("** i2c_master_register_access_unit: FAILED **");
    end
    $finish;
  end
endmodule
